FILE: design/dtoi_pkg.sv
// Shared types and constants for the decimal text to integer converter.
`default_nettype none

package dtoi_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SYNTAX = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    localparam int OUT_BITS    = 256;
    localparam int TDATA_BITS  = 264;

    // queue depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SIGN_NEG,
        KIND_SIGN_POS,
        KIND_DIGIT,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
        logic       last;
    } dtoi_entry_t;

endpackage

`default_nettype wire

FILE: design/dtoi_front.sv
// Front end: takes characters and classifies them as sign, digit, bad or empty.
`default_nettype none

module dtoi_front
    import dtoi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] no_char
    input  wire logic        s_tlast,
    input  wire logic        q_full,
    output logic             q_push,
    output dtoi_entry_t      q_entry
);

    logic first_reg;
    logic first_next;
    logic accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb begin
        q_entry.last  = s_tlast;
        q_entry.digit = 4'(s_tdata - CHAR_ZERO);
        if (s_tuser) begin
            q_entry.kind = KIND_NONE;
        end else if (first_reg && s_tdata == CHAR_MINUS) begin
            q_entry.kind = KIND_SIGN_NEG;
        end else if (first_reg && s_tdata == CHAR_PLUS) begin
            q_entry.kind = KIND_SIGN_POS;
        end else if (s_tdata inside {[CHAR_ZERO:CHAR_NINE]}) begin
            q_entry.kind = KIND_DIGIT;
        end else begin
            q_entry.kind = KIND_BAD;
        end
    end

    // a sign is only a sign as the first character of a text
    always_comb begin
        first_next = first_reg;
        if (accept) begin
            if (s_tlast) begin
                first_next = 1'b1;
            end else if (!s_tuser) begin
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dtoi_fifo.sv
// Short queue of classified words between front and back end.
`default_nettype none

module dtoi_fifo
    import dtoi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire dtoi_entry_t  push_entry,
    output logic              full,
    output logic              not_empty,
    input  wire logic         pop,
    output dtoi_entry_t       head
);

    dtoi_entry_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dtoi_back.sv
// Back end: multiply-by-ten accumulate, overflow check, result register.
`default_nettype none

module dtoi_back
    import dtoi_pkg::*;
#(
    parameter int VALUE_BITS = 256
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  wire dtoi_entry_t            q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [1:0] status, [65:2] value_limb0, [129:66] value_limb1,
    // [193:130] value_limb2, [257:194] value_limb3, rest zero
    output logic [TDATA_BITS-1:0]       m_tdata
);

    // width is held to 64..256
    localparam int VB_EFF = (VALUE_BITS < 64) ? 64 : ((VALUE_BITS > 256) ? 256 : VALUE_BITS);
    localparam int SW = VB_EFF + 4;
    localparam logic [SW-1:0] LIM_NEG = SW'(1) << (VB_EFF - 1);
    localparam logic [SW-1:0] LIM_POS = LIM_NEG - SW'(1);

    logic [VB_EFF-1:0]     acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic                  seen_reg, seen_next;
    logic [1:0]            err_reg, err_next;

    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic                  out_neg_reg;
    logic [VB_EFF-1:0]     out_mag_reg;

    logic                  out_free;
    logic [SW-1:0]         sum;
    logic                  ovf;
    logic [1:0]            status_final;
    logic [VB_EFF-1:0]     signed_val;
    logic [OUT_BITS-1:0]   val_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_head.last || out_free);

    // acc * 10 + digit; one bound check covers both the multiply and the add
    assign sum = SW'({acc_reg, 3'b000}) + SW'({acc_reg, 1'b0}) + SW'(q_head.digit);
    assign ovf = sum > (neg_reg ? LIM_NEG : LIM_POS);

    always_comb begin
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        seen_next = seen_reg;
        err_next  = err_reg;
        if (err_reg == STATUS_OK) begin
            case (q_head.kind)
                KIND_SIGN_NEG: neg_next = 1'b1;
                KIND_SIGN_POS: neg_next = 1'b0;
                KIND_DIGIT: begin
                    seen_next = 1'b1;
                    if (ovf) begin
                        err_next = STATUS_RANGE;
                    end else begin
                        acc_next = sum[VB_EFF-1:0];
                    end
                end
                KIND_BAD: begin
                    seen_next = 1'b1;
                    err_next  = STATUS_SYNTAX;
                end
                default: ;
            endcase
        end
        if (err_next != STATUS_OK) begin
            status_final = err_next;
        end else if (!seen_next) begin
            status_final = STATUS_SYNTAX;
        end else begin
            status_final = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            seen_reg <= 1'b0;
            err_reg  <= STATUS_OK;
        end else if (q_pop) begin
            if (q_head.last) begin
                acc_reg  <= '0;
                neg_reg  <= 1'b0;
                seen_reg <= 1'b0;
                err_reg  <= STATUS_OK;
            end else begin
                acc_reg  <= acc_next;
                neg_reg  <= neg_next;
                seen_reg <= seen_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_head.last) begin
            out_status_reg <= status_final;
            out_neg_reg    <= neg_next;
            out_mag_reg    <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop && q_head.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign signed_val = out_neg_reg ? (~out_mag_reg + VB_EFF'(1)) : out_mag_reg;

    always_comb begin
        for (int i = 0; i < OUT_BITS; i++) begin
            if (out_status_reg != STATUS_OK) begin
                val_ext[i] = 1'b0;
            end else if (i < VB_EFF) begin
                val_ext[i] = signed_val[i];
            end else begin
                val_ext[i] = signed_val[VB_EFF-1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'({val_ext, out_status_reg});

endmodule

`default_nettype wire

FILE: design/decimal_text_to_int256.sv
// Path: the word with tlast is written into the queue, then popped into the result
// register, where m_tvalid rises; the pop waits while an earlier result word is stalled.
// Throughput: one character word per cycle while the queue is not full; the back end's
// multiply-by-ten and bound compare take one entry each cycle; a two-entry queue sits between.
// A stalled result word holds up input only once the next tlast word reaches the queue head.
// Reset (aresetn low, synchronous) empties the queue and clears the accumulator.
`default_nettype none

module decimal_text_to_int256
    import dtoi_pkg::*;
#(
    parameter int VALUE_BITS = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] char_code
    input  wire logic                  s_tuser,   // [0] no_char
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] status, [65:2] value_limb0, [129:66] value_limb1,
    // [193:130] value_limb2, [257:194] value_limb3, rest zero
    output logic [TDATA_BITS-1:0]      m_tdata
);

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    dtoi_entry_t q_in;
    dtoi_entry_t q_head;

    dtoi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    dtoi_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .head       (q_head)
    );

    dtoi_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
